@@ rtl/core/dpht_pkg.sv @@
// Package for the depth-preferred hash table: table geometry, slot entry type and codes.
// Used by the slot store and the top level; it depends on nothing else.
`default_nettype none

package dpht_pkg;

	localparam int TABLE_SLOTS = 65536;
	localparam int IDX_W       = $clog2(TABLE_SLOTS);

	typedef logic [IDX_W-1:0] slot_idx_t;

	localparam logic CMD_PROBE = 1'b0;
	localparam logic CMD_STORE = 1'b1;

	localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

	// One table slot as it sits in memory.
	typedef struct packed {
		logic [63:0]        key;
		logic signed [7:0]  depth;
		logic signed [15:0] score;
		logic [1:0]         flag;
		logic [31:0]        move;
	} slot_entry_t;

	// Contents of every slot after reset: key zero and depth minus one.
	localparam slot_entry_t ENTRY_EMPTY = '{
		key:   64'd0,
		depth: -8'sd1,
		score: 16'sd0,
		flag:  2'd0,
		move:  32'd0
	};

	// Write request from the update logic to the slot store.
	typedef struct packed {
		logic        en;
		slot_idx_t   idx;
		slot_entry_t entry;
	} slot_wr_t;

endpackage

`default_nettype wire

@@ rtl/core/dpht_if.sv @@
// Valid/ready channel interfaces for table commands and table results.
// Does not depend on dpht_pkg; the payload widths are fixed.
`default_nettype none

interface dpht_req_if;
	logic               valid;
	logic               ready;
	logic               command;
	logic [63:0]        key;
	logic [6:0]         search_depth;
	logic signed [15:0] eval_score;
	logic [1:0]         bound_flag;
	logic [31:0]        chosen_move;

	modport source (output valid, command, key, search_depth, eval_score, bound_flag,
		chosen_move, input ready);
	modport sink (input valid, command, key, search_depth, eval_score, bound_flag,
		chosen_move, output ready);
endinterface

interface dpht_rsp_if;
	logic               valid;
	logic               ready;
	logic               hit;
	logic signed [7:0]  found_depth;
	logic signed [15:0] found_score;
	logic [1:0]         found_flag;
	logic [31:0]        found_move;
	logic               written;
	logic [31:0]        new_key_total;

	modport source (output valid, hit, found_depth, found_score, found_flag, found_move,
		written, new_key_total, input ready);
	modport sink (input valid, hit, found_depth, found_score, found_flag, found_move,
		written, new_key_total, output ready);
endinterface

`default_nettype wire

@@ rtl/core/dpht_slot_store.sv @@
// Slot memory of the hash table with its post-reset clearing sweep and write forwarding.
// Depends on dpht_pkg for the entry type, the write request and the table size.
`default_nettype none

module dpht_slot_store
	import dpht_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        rd_en,
	input  wire slot_idx_t   rd_idx,
	output slot_entry_t      rd_entry,
	input  wire slot_wr_t    wr,
	output logic             busy
);

	slot_entry_t mem [TABLE_SLOTS];

	slot_entry_t rd_data_q;
	slot_idx_t   rd_idx_q;
	logic        clr_busy_q;
	slot_idx_t   clr_idx_q;
	logic        lw_valid_q;
	slot_idx_t   lw_idx_q;
	slot_entry_t lw_entry_q;

	logic        mem_we;
	slot_idx_t   mem_widx;
	slot_entry_t mem_wdata;

	assign mem_we    = clr_busy_q | wr.en;
	assign mem_widx  = clr_busy_q ? clr_idx_q : wr.idx;
	assign mem_wdata = clr_busy_q ? ENTRY_EMPTY : wr.entry;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_widx] <= mem_wdata;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_idx];
			rd_idx_q  <= rd_idx;
		end
	end

	// Clearing sweep: one slot per cycle from index zero up to the last slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + slot_idx_t'(1);
			if (clr_idx_q == '1) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// The most recent write is the current content of its slot, so a match
	// against it always gives fresh data, also when it landed on the read edge.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lw_valid_q <= 1'b0;
		end else if (wr.en) begin
			lw_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			lw_idx_q   <= wr.idx;
			lw_entry_q <= wr.entry;
		end
	end

	assign rd_entry = (lw_valid_q && lw_idx_q == rd_idx_q) ? lw_entry_q : rd_data_q;
	assign busy     = clr_busy_q;

endmodule

`default_nettype wire

@@ rtl/core/depth_preferred_hash_table_top.sv @@
// Top level of the depth-preferred transposition table.
// Depends on dpht_pkg, the channel interfaces in dpht_if.sv and dpht_slot_store.
`default_nettype none

// Usage
// A command transaction on req either probes the slot chosen by the low bits of
// key or stores an entry there; every command gives exactly one result transaction
// on rsp, in command order. A probe reports hit and the stored fields when the
// full stored key equals key. A store replaces the slot when search_depth is at
// least the stored depth, sets written, and bumps the saturating new_key_total
// when the replaced slot held a different key.
// After arst_n is released the slot memory is swept back to its empty contents,
// one slot per cycle over all TABLE_SLOTS (65536) slots; req.ready stays low
// throughout the sweep.
// Flow: an accepted command is registered into the update stage while the slot
// memory read is registered alongside it; the compare, update and write back are
// done in the update stage, and the result is registered into the output register
// that drives rsp.
// Throughput is one command per cycle unless rsp stalls: a store to a slot that the
// next command reads is forwarded from the last-write register in the slot store.
// When rsp is stalled the finished result holds in the output register, one more
// command waits in the update stage, and req.ready drops until rsp moves again.
module depth_preferred_hash_table_top
	import dpht_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	dpht_req_if.sink    req,
	dpht_rsp_if.source  rsp
);

	// Update stage registers.
	logic               valid_s1;
	logic               cmd_s1;
	logic [63:0]        key_s1;
	logic [6:0]         depth_s1;
	logic signed [15:0] score_s1;
	logic [1:0]         flag_s1;
	logic [31:0]        move_s1;

	// Output register.
	logic               rsp_valid_q;
	logic               hit_q;
	logic signed [7:0]  found_depth_q;
	logic signed [15:0] found_score_q;
	logic [1:0]         found_flag_q;
	logic [31:0]        found_move_q;
	logic               written_q;
	logic [31:0]        count_q;

	logic        busy;
	logic        accept;
	logic        fire_s1;
	slot_entry_t entry;
	slot_wr_t    wr;
	logic        key_match;
	logic        probe_hit;
	logic        store_ok;
	logic [31:0] count_next;

	dpht_slot_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_idx   (req.key[IDX_W-1:0]),
		.rd_entry (entry),
		.wr       (wr),
		.busy     (busy)
	);

	assign fire_s1   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !busy && (!valid_s1 || fire_s1);
	assign accept    = req.valid && req.ready;

	// Decision for the command in the update stage.
	assign key_match = (entry.key == key_s1);
	assign probe_hit = (cmd_s1 == CMD_PROBE) && key_match;
	assign store_ok  = (cmd_s1 == CMD_STORE) && ($signed({1'b0, depth_s1}) >= entry.depth);

	always_comb begin
		count_next = count_q;
		if (store_ok && !key_match && count_q != COUNT_MAX) begin
			count_next = count_q + 32'd1;
		end
	end

	always_comb begin
		wr.en          = fire_s1 && store_ok;
		wr.idx         = key_s1[IDX_W-1:0];
		wr.entry.key   = key_s1;
		wr.entry.depth = $signed({1'b0, depth_s1});
		wr.entry.score = score_s1;
		wr.entry.flag  = flag_s1;
		wr.entry.move  = move_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1   <= req.command;
			key_s1   <= req.key;
			depth_s1 <= req.search_depth;
			score_s1 <= req.eval_score;
			flag_s1  <= req.bound_flag;
			move_s1  <= req.chosen_move;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			if (fire_s1) begin
				rsp_valid_q <= 1'b1;
				count_q     <= count_next;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// A miss and every store report zero in the found fields.
	always_ff @(posedge clk) begin
		if (fire_s1) begin
			hit_q         <= probe_hit;
			found_depth_q <= probe_hit ? entry.depth : 8'sd0;
			found_score_q <= probe_hit ? entry.score : 16'sd0;
			found_flag_q  <= probe_hit ? entry.flag : 2'd0;
			found_move_q  <= probe_hit ? entry.move : 32'd0;
			written_q     <= store_ok;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.hit           = hit_q;
	assign rsp.found_depth   = found_depth_q;
	assign rsp.found_score   = found_score_q;
	assign rsp.found_flag    = found_flag_q;
	assign rsp.found_move    = found_move_q;
	assign rsp.written       = written_q;
	assign rsp.new_key_total = count_q;

endmodule

`default_nettype wire
